// ----- design/sorted_table_key_to_index_macros.svh -----
// Assertion macros of the sorted key table lookup RTL, used by the controller.
`ifndef SORTED_TABLE_KEY_TO_INDEX_MACROS_SVH
`define SORTED_TABLE_KEY_TO_INDEX_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define STKI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("stki: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define STKI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("stki: next-cycle check failed");

`endif

// ----- design/stki_pkg.sv -----
// Package with shared constants and types of the sorted key table lookup.
`default_nettype none

package stki_pkg;

    localparam int TABLE_DEPTH_DEF = 4096;
    localparam int KEY_WIDTH_DEF   = 64;

    localparam int POS_W       = 12;
    localparam int KEY_W       = 64;
    localparam int BASE_W      = 4;
    localparam int LSIZE_W     = 13;
    localparam int ID_W        = 14;
    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 16;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // register index, taken from paddr[2]
    localparam logic REG_BASE_OFFSET = 1'b0;
    localparam logic REG_LIST_SIZE   = 1'b1;

    typedef struct packed {
        logic load;
        logic start;
        logic step;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic empty;
        logic last;
    } t_dp_stat;

endpackage

`default_nettype wire

// ----- design/stki_ram.sv -----
// Generic simple dual-port RAM with registered read.
`default_nettype none

module stki_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- design/stki_ctrl.sv -----
// Controller state machine of the sorted key table lookup.
`default_nettype none
`include "sorted_table_key_to_index_macros.svh"

module stki_ctrl
    import stki_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire logic     i_in_func,
    input  wire logic     i_out_ready,
    input  wire t_dp_stat i_stat,
    output logic          o_in_ready,
    output logic          o_out_valid,
    output t_dp_cmd       o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_FINISH
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   in_acc;
    t_dp_cmd cmd;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in_func == FUNC_LOAD) begin
                        cmd.load = 1'b1;
                    end else begin
                        cmd.start = 1'b1;
                        n_state   = i_stat.empty ? S_FINISH : S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                cmd.step = 1'b1;
                if (i_stat.last) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    cmd.emit = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    // a new result never overwrites one that is still waiting
    `STKI_ASSERT_NOW(a_emit_space, i_clk, i_rst_n, cmd.emit, !r_out_valid || i_out_ready)
    // a waiting result is never dropped
    `STKI_ASSERT_NEXT(a_hold_result, i_clk, i_rst_n, r_out_valid && !i_out_ready, r_out_valid)
    // the final halving step always leads to the result stage
    `STKI_ASSERT_NEXT(a_step_done, i_clk, i_rst_n, cmd.step && i_stat.last, r_state == S_FINISH)
    // a query on a non-empty list starts searching
    `STKI_ASSERT_NEXT(a_start_search, i_clk, i_rst_n, cmd.start && !i_stat.empty,
                      r_state == S_SEARCH)

endmodule

`default_nettype wire

// ----- design/stki_dp.sv -----
// Datapath of the sorted key table lookup: key table, search bounds, result.
`default_nettype none

module stki_dp
    import stki_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int KEY_WIDTH   = KEY_WIDTH_DEF
) (
    input  wire logic               i_clk,
    input  wire t_dp_cmd            i_cmd,
    input  wire logic [POS_W-1:0]   i_pos,
    input  wire logic [KEY_W-1:0]   i_key,
    input  wire logic               i_last,
    input  wire logic [BASE_W-1:0]  i_base_offset,
    input  wire logic [LSIZE_W-1:0] i_list_size,
    output t_dp_stat                o_stat,
    output logic [ID_W-1:0]         o_local_id,
    output logic                    o_found,
    output logic                    o_last
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [CW-1:0]        n_sat, mid0;
    logic [CW-1:0]        r_lo, r_hi, r_mid;
    logic [CW-1:0]        n_lo, n_hi, n_mid;
    logic                 r_eq, n_eq;
    logic [KEY_WIDTH-1:0] r_key;
    logic                 r_last;
    logic [KEY_WIDTH-1:0] rdata;
    logic                 lt;
    logic                 we;
    logic [ID_W-1:0]      r_id, id;
    logic                 r_found, r_out_last;

    // clamp the searched length to the table depth
    always_comb begin
        if (32'(i_list_size) > 32'(TABLE_DEPTH)) begin
            n_sat = CW'(TABLE_DEPTH);
        end else begin
            n_sat = CW'(i_list_size);
        end
    end

    assign mid0 = n_sat >> 1;
    assign we   = i_cmd.load && (32'(i_pos) < 32'(TABLE_DEPTH));

    stki_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (AW'(i_pos)),
        .i_wdata (i_key[KEY_WIDTH-1:0]),
        .i_raddr (AW'(i_cmd.start ? mid0 : n_mid)),
        .o_rdata (rdata)
    );

    // one halving step on the entry read at r_mid
    always_comb begin
        lt    = (rdata < r_key);
        n_lo  = lt ? r_mid + CW'(1) : r_lo;
        n_hi  = lt ? r_hi : r_mid;
        n_eq  = lt ? r_eq : (rdata == r_key);
        n_mid = n_lo + ((n_hi - n_lo) >> 1);
    end

    assign o_stat.empty = (n_sat == '0);
    assign o_stat.last  = !(n_lo < n_hi);

    // r_eq tells whether the entry at the final bound matched
    assign id = r_eq ? ID_W'(r_lo) + ID_W'(i_base_offset)
                     : ID_W'(i_base_offset) - ID_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_key  <= i_key[KEY_WIDTH-1:0];
            r_lo   <= '0;
            r_hi   <= n_sat;
            r_mid  <= mid0;
            r_eq   <= 1'b0;
            r_last <= i_last;
        end else if (i_cmd.step) begin
            r_lo  <= n_lo;
            r_hi  <= n_hi;
            r_mid <= n_mid;
            r_eq  <= n_eq;
        end
        if (i_cmd.emit) begin
            r_id       <= id;
            r_found    <= r_eq;
            r_out_last <= r_last;
        end
    end

    assign o_local_id = r_id;
    assign o_found    = r_found;
    assign o_last     = r_out_last;

endmodule

`default_nettype wire

// ----- design/sorted_table_key_to_index.sv -----
// Top level of the sorted key table lookup: channels, register port, wiring.
// Usage:
//   Input stream s_axis: tuser selects the item kind (0 load, 1 query),
//   tdata carries the table position and the key, tlast marks the final
//   query of a batch. A load writes one table entry and gives no result.
//   A query runs a lower-bound binary search over the first list_size
//   entries and gives one result on m_axis: tdata holds local_id
//   (position plus base_offset on a hit, base_offset minus one on a miss),
//   tuser holds found, tlast echoes the query's tlast.
//   Sequence: a load is written to the table as it is accepted. A query
//   is accepted, then runs one halving step per entry read (ceil(log2(n+1))
//   steps at most for n searched entries, 13 for 4096), then loads the
//   result register. The search loop is bounded by the one read port of
//   the key table, one entry per cycle.
//   The result register frees the input side: the next item is taken as
//   soon as the search hands off its result, even while m_axis stalls; a
//   finished search waits in place if the result register is still full.
//   Reset clears the controller, the result valid flag and both registers;
//   table contents stay undefined until loaded, and no clearing pass runs.
//   Registers: base_offset at byte address 0, list_size at address 4.
`default_nettype none

module sorted_table_key_to_index
    import stki_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int KEY_WIDTH   = KEY_WIDTH_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // input items
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,  // entry_position[11:0], key[75:12], 0 pad
    input  wire logic                   s_axis_tuser,  // func
    input  wire logic                   s_axis_tlast,  // last_query
    // result items
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,  // local_id[13:0], 0 pad
    output logic                        m_axis_tuser,  // found
    output logic                        m_axis_tlast,  // last_result
    // register port
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [APB_ADDR_W-1:0]  paddr,
    input  wire logic [APB_DATA_W-1:0]  pwdata,
    output logic      [APB_DATA_W-1:0]  prdata,
    output logic                        pready
);

    logic [BASE_W-1:0]  r_base_offset;
    logic [LSIZE_W-1:0] r_list_size;
    logic               cfg_wr;
    t_dp_cmd            cmd;
    t_dp_stat           stat;
    logic [ID_W-1:0]    local_id;

    // configuration registers; only paddr[2] selects
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_offset <= '0;
            r_list_size   <= '0;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_BASE_OFFSET) begin
                r_base_offset <= pwdata[BASE_W-1:0];
            end else begin
                r_list_size <= pwdata[LSIZE_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_LIST_SIZE) begin
            prdata = APB_DATA_W'(r_list_size);
        end else begin
            prdata = APB_DATA_W'(r_base_offset);
        end
    end

    // sequence load, search steps and result hand-off
    stki_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_func   (s_axis_tuser),
        .i_out_ready (m_axis_tready),
        .i_stat      (stat),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (cmd)
    );

    // key table, search bounds and result register
    stki_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_WIDTH   (KEY_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_cmd         (cmd),
        .i_pos         (s_axis_tdata[POS_W-1:0]),
        .i_key         (s_axis_tdata[POS_W+KEY_W-1:POS_W]),
        .i_last        (s_axis_tlast),
        .i_base_offset (r_base_offset),
        .i_list_size   (r_list_size),
        .o_stat        (stat),
        .o_local_id    (local_id),
        .o_found       (m_axis_tuser),
        .o_last        (m_axis_tlast)
    );

    assign m_axis_tdata = OUT_TDATA_W'(local_id);

endmodule

`default_nettype wire
